### rtl/hfrq_pkg.sv
// Package: shared widths, codes and the control/status structs of the ready queue.
`default_nettype none

package hfrq_pkg;

  localparam int PID_W      = 32;
  localparam int TIME_W     = 32;
  localparam int EST_W      = 24;
  localparam int ALPHA_W    = 9;
  localparam int STAT_W     = 2;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 9;
  localparam int EST_FRAC   = 8;
  localparam int NUM_W      = TIME_W + 1;
  localparam int PROD_W     = NUM_W + EST_W;
  localparam int EPROD_W    = ALPHA_W + EST_W;
  localparam int ESUM_W     = EPROD_W + 1;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DSP = 1'b1;

  localparam logic [CFG_ADDR_W-1:0] CFG_POLICY = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ALPHA  = 1'b1;

  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_HRRN = 1'b1;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 9'd256;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd128;
  localparam logic [ESUM_W-1:0]  EST_ROUND   = ESUM_W'(128);

  typedef struct packed {
    logic [PID_W-1:0]  pid;
    logic [TIME_W-1:0] arrival;
    logic [EST_W-1:0]  est;
  } entry_t;

  typedef struct packed {
    logic latch_in;
    logic est_mul_a;
    logic est_mul_b;
    logic est_finish;
    logic dsp_empty;
    logic rd_first;
    logic load_best;
    logic rd_idx;
    logic load_cand;
    logic mul;
    logic cmp;
    logic shift_rd;
    logic shift_wr;
    logic dsp_finish;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic hrrn;
    logic scan_done;
    logic scan_last;
    logic shift_done;
  } dp_stat_t;

endpackage

`default_nettype wire

### rtl/hfrq_ctrl.sv
// Controller: sequences enqueue, dispatch scan and table compaction.
`default_nettype none

module hfrq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               in_cmd,
  input  hfrq_pkg::dp_stat_t stat,
  output hfrq_pkg::dp_cmd_t  cmd,
  output logic               busy
);
  import hfrq_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE      = 11'b000_0000_0001,
    S_EST_A     = 11'b000_0000_0010,
    S_EST_B     = 11'b000_0000_0100,
    S_EST_END   = 11'b000_0000_1000,
    S_DSP_CHK   = 11'b000_0001_0000,
    S_DSP_LD0   = 11'b000_0010_0000,
    S_SCAN_LD   = 11'b000_0100_0000,
    S_SCAN_MUL  = 11'b000_1000_0000,
    S_SCAN_CMP  = 11'b001_0000_0000,
    S_SHIFT_CHK = 11'b010_0000_0000,
    S_SHIFT_WR  = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch_in = 1'b1;
          state_nxt    = (in_cmd == CMD_DSP) ? S_DSP_CHK : S_EST_A;
        end
      end
      S_EST_A: begin
        cmd.est_mul_a = 1'b1;
        state_nxt     = S_EST_B;
      end
      S_EST_B: begin
        cmd.est_mul_b = 1'b1;
        state_nxt     = S_EST_END;
      end
      S_EST_END: begin
        cmd.est_finish = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_DSP_CHK: begin
        if (stat.empty) begin
          cmd.dsp_empty = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.rd_first = 1'b1;
          state_nxt    = S_DSP_LD0;
        end
      end
      S_DSP_LD0: begin
        cmd.load_best = 1'b1;
        if (stat.hrrn && !stat.scan_done) begin
          cmd.rd_idx = 1'b1;
          state_nxt  = S_SCAN_LD;
        end else begin
          state_nxt  = S_SHIFT_CHK;
        end
      end
      S_SCAN_LD: begin
        cmd.load_cand = 1'b1;
        state_nxt     = S_SCAN_MUL;
      end
      S_SCAN_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = stat.scan_last ? S_SHIFT_CHK : S_SCAN_LD;
      end
      S_SHIFT_CHK: begin
        if (stat.shift_done) begin
          cmd.dsp_finish = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cmd.shift_rd = 1'b1;
          state_nxt    = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.shift_wr = 1'b1;
        state_nxt    = S_SHIFT_CHK;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/hfrq_dp.sv
// Datapath: entry table, estimate update, ratio compare and result registers.
`default_nettype none

module hfrq_dp #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  hfrq_pkg::dp_cmd_t                    cmd,
  output hfrq_pkg::dp_stat_t                   stat,
  input  logic [hfrq_pkg::PID_W-1:0]           in_proc_id,
  input  logic [hfrq_pkg::TIME_W-1:0]          in_arrival_ms,
  input  logic [hfrq_pkg::EST_W-1:0]           in_prev_estimate_ms,
  input  logic [hfrq_pkg::EST_W-1:0]           in_last_burst_ms,
  input  logic [hfrq_pkg::TIME_W-1:0]          in_now_ms,
  input  logic                                 cfg_we,
  input  logic [hfrq_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [hfrq_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic                                 out_valid,
  output logic [hfrq_pkg::STAT_W-1:0]          out_status,
  output logic [hfrq_pkg::PID_W-1:0]           out_chosen_id,
  output logic [hfrq_pkg::EST_W-1:0]           out_estimate_ms
);
  import hfrq_pkg::*;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t mem [QUEUE_DEPTH];
  entry_t rdata_r;

  logic               policy_r;
  logic [ALPHA_W-1:0] alpha_r;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] idx_r;
  logic [CNT_W-1:0] k_r;

  logic [PID_W-1:0]  pid_r;
  logic [TIME_W-1:0] arrival_r;
  logic [EST_W-1:0]  prev_r;
  logic [EST_W-1:0]  last_r;
  logic [TIME_W-1:0] now_r;

  logic [EPROD_W-1:0] est_pa_r;
  logic [EPROD_W-1:0] est_pb_r;

  logic [PID_W-1:0] cand_pid_r, best_pid_r;
  logic [EST_W-1:0] cand_est_r, best_est_r;
  logic [NUM_W-1:0] cand_n_r, best_n_r;
  logic [EST_W-1:0] cand_e_r, best_e_r;

  logic [PROD_W-1:0] prod_l_r;
  logic [PROD_W-1:0] prod_r_r;

  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [PID_W-1:0]  out_chosen_id_r;
  logic [EST_W-1:0]  out_estimate_r;

  logic [ALPHA_W-1:0] a_sat;
  logic [ESUM_W-1:0]  est_sum;
  logic [EST_W-1:0]   est_new;
  logic               full;
  logic [CNT_W:0]     idx_inc;
  logic [CNT_W:0]     k_inc;
  logic [TIME_W-1:0]  ld_wait;
  logic [EST_W-1:0]   ld_e;
  logic [NUM_W-1:0]   ld_n;
  logic               better;
  logic               rd_en;
  logic [IDX_W-1:0]   raddr;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  entry_t             wdata;

  assign a_sat   = alpha_r[ALPHA_W-1] ? ALPHA_ONE : alpha_r;
  assign est_sum = ESUM_W'(est_pa_r) + ESUM_W'(est_pb_r) + EST_ROUND;
  assign est_new = est_sum[EST_FRAC +: EST_W];
  assign full    = (count_r >= CNT_W'(QUEUE_DEPTH));
  assign idx_inc = (CNT_W+1)'(idx_r) + (CNT_W+1)'(1);
  assign k_inc   = (CNT_W+1)'(k_r) + (CNT_W+1)'(1);

  assign ld_wait = (now_r >= rdata_r.arrival) ? (now_r - rdata_r.arrival) : '0;
  assign ld_e    = (rdata_r.est == '0) ? EST_W'(1) : rdata_r.est;
  assign ld_n    = NUM_W'(ld_wait) + NUM_W'(ld_e);
  assign better  = (prod_l_r > prod_r_r);

  assign stat.empty      = (count_r == '0);
  assign stat.hrrn       = (policy_r == POLICY_HRRN);
  assign stat.scan_done  = (idx_r == count_r);
  assign stat.scan_last  = (idx_inc == (CNT_W+1)'(count_r));
  assign stat.shift_done = (k_inc >= (CNT_W+1)'(count_r));

  assign rd_en = cmd.rd_first | cmd.rd_idx | cmd.cmp | cmd.shift_rd;

  always_comb begin
    priority if (cmd.rd_first) begin
      raddr = '0;
    end else if (cmd.rd_idx) begin
      raddr = idx_r[IDX_W-1:0];
    end else if (cmd.cmp) begin
      raddr = idx_inc[IDX_W-1:0];
    end else begin
      raddr = k_inc[IDX_W-1:0];
    end
  end

  assign we    = (cmd.est_finish && !full) || cmd.shift_wr;
  assign waddr = cmd.shift_wr ? k_r[IDX_W-1:0] : count_r[IDX_W-1:0];

  always_comb begin
    if (cmd.shift_wr) begin
      wdata = rdata_r;
    end else begin
      wdata.pid     = pid_r;
      wdata.arrival = arrival_r;
      wdata.est     = est_new;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POLICY_FIFO;
      alpha_r  <= ALPHA_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_POLICY: policy_r <= cfg_wdata[0];
        CFG_ALPHA:  alpha_r  <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.est_finish | cmd.dsp_empty | cmd.dsp_finish;
      if (cmd.est_finish && !full) begin
        count_r <= count_r + CNT_W'(1);
      end else if (cmd.dsp_finish) begin
        count_r <= count_r - CNT_W'(1);
      end
      if (cmd.rd_first) begin
        idx_r <= CNT_W'(1);
      end else if (cmd.cmp) begin
        idx_r <= idx_inc[CNT_W-1:0];
      end
      if (cmd.load_best) begin
        k_r <= '0;
      end else if (cmd.cmp && better) begin
        k_r <= idx_r;
      end else if (cmd.shift_wr) begin
        k_r <= k_inc[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      pid_r     <= in_proc_id;
      arrival_r <= in_arrival_ms;
      prev_r    <= in_prev_estimate_ms;
      last_r    <= in_last_burst_ms;
      now_r     <= in_now_ms;
    end
    if (cmd.est_mul_a) begin
      est_pa_r <= EPROD_W'(a_sat) * EPROD_W'(last_r);
    end
    if (cmd.est_mul_b) begin
      est_pb_r <= EPROD_W'(ALPHA_ONE - a_sat) * EPROD_W'(prev_r);
    end
    if (cmd.load_best) begin
      best_pid_r <= rdata_r.pid;
      best_est_r <= rdata_r.est;
      best_n_r   <= ld_n;
      best_e_r   <= ld_e;
    end else if (cmd.cmp && better) begin
      best_pid_r <= cand_pid_r;
      best_est_r <= cand_est_r;
      best_n_r   <= cand_n_r;
      best_e_r   <= cand_e_r;
    end
    if (cmd.load_cand) begin
      cand_pid_r <= rdata_r.pid;
      cand_est_r <= rdata_r.est;
      cand_n_r   <= ld_n;
      cand_e_r   <= ld_e;
    end
    if (cmd.mul) begin
      prod_l_r <= PROD_W'(cand_n_r) * PROD_W'(best_e_r);
      prod_r_r <= PROD_W'(best_n_r) * PROD_W'(cand_e_r);
    end
    if (cmd.est_finish) begin
      out_status_r    <= full ? STAT_FULL : STAT_DONE;
      out_chosen_id_r <= pid_r;
      out_estimate_r  <= est_new;
    end else if (cmd.dsp_empty) begin
      out_status_r    <= STAT_EMPTY;
      out_chosen_id_r <= '0;
      out_estimate_r  <= '0;
    end else if (cmd.dsp_finish) begin
      out_status_r    <= STAT_DONE;
      out_chosen_id_r <= best_pid_r;
      out_estimate_r  <= best_est_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_chosen_id   = out_chosen_id_r;
  assign out_estimate_ms = out_estimate_r;

endmodule

`default_nettype wire

### rtl/hrrn_fifo_ready_queue_top.sv
// Top level: ready queue with FIFO or highest-response-ratio dispatch.
// Enqueue: the result strobe follows the estimate update; a new request is taken only when idle.
// Dispatch of n entries: FIFO mode takes the head entry and compacts the table; HRRN mode
// first scans it (load, multiply, compare per entry), then compacts (read, write per moved entry).
// Reset (synchronous, rst_n low) empties the table and restores policy and alpha.
`default_nettype none

module hrrn_fifo_ready_queue_top #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_cmd,
  input  logic [hfrq_pkg::PID_W-1:0]      in_proc_id,
  input  logic [hfrq_pkg::TIME_W-1:0]     in_arrival_ms,
  input  logic [hfrq_pkg::EST_W-1:0]      in_prev_estimate_ms,
  input  logic [hfrq_pkg::EST_W-1:0]      in_last_burst_ms,
  input  logic [hfrq_pkg::TIME_W-1:0]     in_now_ms,
  output logic                            out_valid,
  output logic [hfrq_pkg::STAT_W-1:0]     out_status,
  output logic [hfrq_pkg::PID_W-1:0]      out_chosen_id,
  output logic [hfrq_pkg::EST_W-1:0]      out_estimate_ms,
  input  logic                            cfg_we,
  input  logic [hfrq_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [hfrq_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import hfrq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  hfrq_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  hfrq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_proc_id          (in_proc_id),
    .in_arrival_ms       (in_arrival_ms),
    .in_prev_estimate_ms (in_prev_estimate_ms),
    .in_last_burst_ms    (in_last_burst_ms),
    .in_now_ms           (in_now_ms),
    .cfg_we              (cfg_we),
    .cfg_addr            (cfg_addr),
    .cfg_wdata           (cfg_wdata),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_chosen_id       (out_chosen_id),
    .out_estimate_ms     (out_estimate_ms)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request taken but block not busy");

  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without preceding work");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_EMPTY) |-> (out_chosen_id == '0 && out_estimate_ms == '0))
    else $error("empty dispatch carries non-zero payload");

endmodule

`default_nettype wire

### tb/tb_hrrn_fifo_ready_queue_top.sv
// Self-checking testbench for the ready queue: directed and random requests against a scoreboard.
`timescale 1ns / 1ps

module tb_hrrn_fifo_ready_queue_top;
  import hfrq_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int SETTLE_CYCLES = 120;
  localparam logic [EST_W-1:0] EST_MAX = {EST_W{1'b1}};
  localparam logic [PID_W-1:0] PID_MAX = {PID_W{1'b1}};
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [PID_W-1:0]  pid;
    logic [EST_W-1:0]  est;
  } sched_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic                  in_cmd;
  logic [PID_W-1:0]      in_proc_id;
  logic [TIME_W-1:0]     in_arrival_ms;
  logic [EST_W-1:0]      in_prev_estimate_ms;
  logic [EST_W-1:0]      in_last_burst_ms;
  logic [TIME_W-1:0]     in_now_ms;
  logic                  out_valid;
  logic [STAT_W-1:0]     out_status;
  logic [PID_W-1:0]      out_chosen_id;
  logic [EST_W-1:0]      out_estimate_ms;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  logic               sched_policy;
  logic [ALPHA_W-1:0] sched_alpha;
  int                 table_fill;
  logic [PID_W-1:0]   table_pid [TABLE_DEPTH];
  logic [TIME_W-1:0]  table_arrival [TABLE_DEPTH];
  logic [EST_W-1:0]   table_est [TABLE_DEPTH];

  sched_result_t pending_results[$];
  logic [TIME_W-1:0] clock_ms;
  bit no_gaps;
  int error_count, n_enq, n_full, n_dsp, n_empty, n_hrrn, n_cfg;

  hrrn_fifo_ready_queue_top #(.QUEUE_DEPTH(TABLE_DEPTH)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_proc_id(in_proc_id), .in_arrival_ms(in_arrival_ms),
    .in_prev_estimate_ms(in_prev_estimate_ms), .in_last_burst_ms(in_last_burst_ms),
    .in_now_ms(in_now_ms), .out_valid(out_valid), .out_status(out_status),
    .out_chosen_id(out_chosen_id), .out_estimate_ms(out_estimate_ms),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [EST_W-1:0] blend_estimate(logic [EST_W-1:0] prev,
                                                      logic [EST_W-1:0] last);
    logic [63:0] a;
    logic [63:0] acc;
    a = (sched_alpha > ALPHA_ONE) ? 64'(ALPHA_ONE) : 64'(sched_alpha);
    acc = a * 64'(last) + (64'd256 - a) * 64'(prev) + 64'd128;
    return acc[EST_FRAC +: EST_W];
  endfunction

  function automatic logic [63:0] est_at_least_one(logic [EST_W-1:0] e);
    return (e == '0) ? 64'd1 : 64'(e);
  endfunction

  function automatic logic [63:0] ratio_numer(int k, logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] w;
    w = (now >= table_arrival[k]) ? now - table_arrival[k] : '0;
    return 64'(w) + est_at_least_one(table_est[k]);
  endfunction

  function automatic sched_result_t apply_request(logic cmd, logic [PID_W-1:0] pid,
                                                  logic [TIME_W-1:0] arrival,
                                                  logic [EST_W-1:0] prev,
                                                  logic [EST_W-1:0] last,
                                                  logic [TIME_W-1:0] now);
    sched_result_t r;
    int pick;
    if (cmd == CMD_ENQ) begin
      r.pid = pid;
      r.est = blend_estimate(prev, last);
      if (table_fill >= TABLE_DEPTH) begin
        r.status = STAT_FULL;
      end else begin
        table_pid[table_fill] = pid;
        table_arrival[table_fill] = arrival;
        table_est[table_fill] = r.est;
        table_fill++;
        r.status = STAT_DONE;
      end
    end else if (table_fill == 0) begin
      r.status = STAT_EMPTY;
      r.pid = '0;
      r.est = '0;
    end else begin
      pick = 0;
      if (sched_policy == POLICY_HRRN) begin
        for (int i = 1; i < table_fill; i++) begin
          if (ratio_numer(i, now) * est_at_least_one(table_est[pick]) >
              ratio_numer(pick, now) * est_at_least_one(table_est[i]))
            pick = i;
        end
      end
      r.status = STAT_DONE;
      r.pid = table_pid[pick];
      r.est = table_est[pick];
      for (int i = pick; i < table_fill - 1; i++) begin
        table_pid[i] = table_pid[i + 1];
        table_arrival[i] = table_arrival[i + 1];
        table_est[i] = table_est[i + 1];
      end
      table_fill--;
    end
    return r;
  endfunction

  task automatic send_request(input logic cmd, input logic [PID_W-1:0] pid,
                              input logic [TIME_W-1:0] arrival, input logic [EST_W-1:0] prev,
                              input logic [EST_W-1:0] last, input logic [TIME_W-1:0] now);
    sched_result_t r;
    @(negedge clk);
    start = 1'b1;
    in_cmd = cmd;
    in_proc_id = pid;
    in_arrival_ms = arrival;
    in_prev_estimate_ms = prev;
    in_last_burst_ms = last;
    in_now_ms = now;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = apply_request(cmd, pid, arrival, prev, last, now);
    pending_results.push_back(r);
    if (cmd == CMD_ENQ) begin
      n_enq++;
      if (r.status == STAT_FULL) n_full++;
    end else begin
      n_dsp++;
      if (r.status == STAT_EMPTY) n_empty++;
      else if (sched_policy == POLICY_HRRN) n_hrrn++;
    end
  endtask

  task automatic idle_gap();
    int n;
    int roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 55) n = 0;
    else if (roll < 90) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 60);
    if (n > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    while (busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_POLICY) sched_policy = val[0];
    else sched_alpha = val;
    n_cfg++;
  endtask

  function automatic logic [EST_W-1:0] rand_est();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return EST_W'($urandom_range(0, 3000));
    if (roll < 80) return '0;
    if (roll < 90) return EST_MAX;
    return EST_W'($urandom());
  endfunction

  function automatic logic [TIME_W-1:0] rand_arrival();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return clock_ms - TIME_W'($urandom_range(0, 5000));
    if (roll < 85) return clock_ms + TIME_W'($urandom_range(1, 3000));
    return $urandom();
  endfunction

  task automatic random_request(input int enq_pct);
    logic cmd;
    logic [TIME_W-1:0] now;
    cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DSP;
    clock_ms = clock_ms + TIME_W'($urandom_range(0, 200));
    now = ($urandom_range(0, 99) < 80) ? clock_ms : $urandom();
    send_request(cmd, $urandom(), rand_arrival(), rand_est(), rand_est(), now);
    idle_gap();
  endtask

  task automatic run_phase(input logic policy, input logic [ALPHA_W-1:0] alpha,
                           input int enq_pct, input bit gaps, input int n);
    write_reg(CFG_POLICY, {CFG_DATA_W'($urandom_range(0, 255)) << 1} | CFG_DATA_W'(policy));
    write_reg(CFG_ALPHA, alpha);
    no_gaps = !gaps;
    for (int i = 0; i < n; i++) begin
      // hold off until the table has answered everything
      if (i == n / 2) wait_drained();
      random_request(enq_pct);
    end
  endtask

  task automatic test_after_reset();
    send_request(CMD_DSP, PID_MAX, TIME_MAX, EST_MAX, EST_MAX, TIME_MAX);
    send_request(CMD_ENQ, 32'h0000_0001, 32'd10, 24'd0, 24'd1, 32'd0);
    send_request(CMD_DSP, '0, '0, '0, '0, 32'd5);
  endtask

  task automatic test_estimate_update();
    write_reg(CFG_ALPHA, 9'd0);
    send_request(CMD_ENQ, '0, '0, EST_MAX, 24'd0, '0);
    write_reg(CFG_ALPHA, ALPHA_ONE);
    send_request(CMD_ENQ, PID_MAX, TIME_MAX, 24'd0, EST_MAX, TIME_MAX);
    write_reg(CFG_ALPHA, 9'h1FF);
    send_request(CMD_ENQ, 32'hA5A5_5A5A, 32'd1000, EST_MAX, 24'd0, '0);
    write_reg(CFG_ALPHA, 9'd300);
    send_request(CMD_ENQ, 32'h5A5A_A5A5, 32'd1000, 24'd5, 24'd7, '0);
    write_reg(CFG_ALPHA, 9'd1);
    send_request(CMD_ENQ, 32'h1234_5678, 32'd2000, 24'd0, EST_MAX, '0);
  endtask

  task automatic test_full_table();
    write_reg(CFG_ALPHA, ALPHA_RESET);
    // tie pairs: same arrival and estimate
    while (table_fill < TABLE_DEPTH)
      send_request(CMD_ENQ, 32'h100 + table_fill, 32'd3000 + 32'(table_fill / 2) * 100,
                   24'd40 + 24'(table_fill / 2), 24'd60, '0);
    send_request(CMD_ENQ, 32'hDEAD_0001, 32'd4000, 24'd9, 24'd9, '0);
  endtask

  task automatic test_hrrn_dispatch();
    write_reg(CFG_POLICY, 9'h155);
    send_request(CMD_DSP, '0, '0, '0, '0, 32'd0);
    send_request(CMD_DSP, '0, '0, '0, '0, TIME_MAX);
    send_request(CMD_DSP, '0, '0, '0, '0, 32'd3500);
  endtask

  task automatic test_random_traffic();
    clock_ms = $urandom();
    run_phase(POLICY_FIFO, ALPHA_RESET, 70, 1'b1, 48);
    run_phase(POLICY_HRRN, ALPHA_W'($urandom_range(0, 256)), 65, 1'b1, 48);
    run_phase(POLICY_HRRN, 9'd0, 40, 1'b0, 48);
    run_phase(POLICY_FIFO, ALPHA_ONE, 55, 1'b1, 48);
    run_phase(POLICY_HRRN, 9'h1FF, 70, 1'b1, 48);
    run_phase(POLICY_HRRN, ALPHA_W'($urandom_range(0, 511)), 35, 1'b1, 48);
    run_phase(POLICY_FIFO, ALPHA_W'($urandom_range(0, 511)), 60, 1'b0, 48);
    run_phase(POLICY_HRRN, ALPHA_RESET, 50, 1'b1, 48);
  endtask

  always @(posedge clk) begin
    sched_result_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: status %0d id %h est %h", $time,
                 out_status, out_chosen_id, out_estimate_ms);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_status !== exp_r.status) begin
          $display("%0t: status expected %0d, actual %0d", $time, exp_r.status, out_status);
          error_count++;
        end
        if (out_chosen_id !== exp_r.pid) begin
          $display("%0t: chosen_id expected %h, actual %h", $time, exp_r.pid, out_chosen_id);
          error_count++;
        end
        if (out_estimate_ms !== exp_r.est) begin
          $display("%0t: estimate expected %h, actual %h", $time, exp_r.est,
                   out_estimate_ms);
          error_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb_hrrn_fifo_ready_queue_top: done, errors");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = CMD_ENQ;
    in_proc_id = '0;
    in_arrival_ms = '0;
    in_prev_estimate_ms = '0;
    in_last_burst_ms = '0;
    in_now_ms = '0;
    cfg_we = 1'b0;
    cfg_addr = CFG_POLICY;
    cfg_wdata = '0;
    sched_policy = POLICY_FIFO;
    sched_alpha = ALPHA_RESET;
    table_fill = 0;
    no_gaps = 1'b0;
    clock_ms = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    test_after_reset();
    test_estimate_update();
    test_full_table();
    test_hrrn_dispatch();
    test_random_traffic();

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("covered %0d enqueues (%0d refused, table full), %0d dispatches", n_enq, n_full,
             n_dsp);
    $display("  (%0d on an empty table, %0d by response ratio), %0d register writes", n_empty,
             n_hrrn, n_cfg);
    if (error_count == 0) begin
      $display("tb_hrrn_fifo_ready_queue_top: done, clean");
    end else begin
      $display("tb_hrrn_fifo_ready_queue_top: done, errors");
    end
    $finish;
  end

endmodule
